// ----- design/cscr_pkg.sv -----
// Package for the clock second-chance page replacer.
// Holds default sizes, field widths and stream packing constants.
// No dependencies.
package cscr_pkg;

    localparam int unsigned FRAMES_DEF    = 16;
    localparam int unsigned PAGE_BITS_DEF = 16;

    localparam int unsigned CFG_W       = 5;
    localparam int unsigned PAGE_W      = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned FAULT_W     = 32;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // output tuser bits
    localparam int unsigned TU_HIT     = 0;
    localparam int unsigned TU_EVICTED = 1;

endpackage

// ----- design/clock_second_chance_replacer.sv -----
// Clock second-chance page replacer: top level, sequencer and frame store.
// Depends on cscr_pkg.
//
// One page request at a time. A request is accepted in the idle state, then a
// linear lookup over the filled frames through one registered memory read port
// and one comparator (skipped on an empty table). Every miss passes a decision
// state; on a full table the clock sweep follows, one frame per cycle, and then
// the replace state. The output register is loaded next, later while the previous
// result is still held. The table is empty after reset and after every
// frames_in_use write; the fault total survives writes.
module clock_second_chance_replacer #(
    parameter int unsigned FRAMES    = cscr_pkg::FRAMES_DEF,
    parameter int unsigned PAGE_BITS = cscr_pkg::PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config: frames_in_use
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cscr_pkg::CFG_W-1:0]         i_cfg_data,
    // request: [15:0] page
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [cscr_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // result: [3:0] frame_slot, [19:4] evicted_page, [51:20] fault_total, rest 0
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [cscr_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // result: [0] hit, [1] evicted_valid
    output logic [cscr_pkg::OUT_TUSER_W-1:0]   o_m_tuser
);

    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned NW = $clog2(FRAMES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_SWEEP,
        S_EVICT,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [cscr_pkg::CFG_W-1:0]    r_fiu;
    logic [PAGE_BITS-1:0]          r_page;
    logic [FRAMES-1:0]             r_ref;
    logic [NW-1:0]                 r_filled;
    logic [IW-1:0]                 r_hand;
    logic [cscr_pkg::FAULT_W-1:0]  r_fault;
    logic [NW-1:0]                 r_idx;
    logic [IW-1:0]                 r_cidx;
    logic                          r_cval;
    logic                          r_res_hit;
    logic                          r_res_ev;
    logic [IW-1:0]                 r_res_slot;
    logic [PAGE_BITS-1:0]          r_res_evp;
    logic                          r_m_tvalid;
    logic [cscr_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic [cscr_pkg::OUT_TUSER_W-1:0] r_m_tuser;

    logic [PAGE_BITS-1:0]          mem [FRAMES];
    logic [PAGE_BITS-1:0]          r_rdata;
    logic [IW-1:0]                 rd_addr;
    logic                          wr_en;

    logic [NW+4:0]                 fiu_ext;
    logic [NW-1:0]                 n_act;
    logic [IW-1:0]                 hand_inc;
    logic [PAGE_BITS+15:0]         page_ext;
    logic [PAGE_BITS+15:0]         evp_ext;
    logic [IW+3:0]                 slot_ext;
    logic                          out_free;
    logic                          cmp_hit;
    logic                          cmp_last;

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        fiu_ext = {{NW{1'b0}}, r_fiu};
        if (r_fiu == '0) begin
            n_act = NW'(1);
        end else if (fiu_ext > (NW + 5)'(FRAMES)) begin
            n_act = NW'(FRAMES);
        end else begin
            n_act = fiu_ext[NW-1:0];
        end
    end

    assign hand_inc = ((NW'(r_hand) + NW'(1)) == n_act) ? '0 : r_hand + IW'(1);
    assign page_ext = {{PAGE_BITS{1'b0}}, i_s_tdata};
    assign evp_ext  = {16'd0, r_res_evp};
    assign slot_ext = {4'd0, r_res_slot};
    assign out_free = !r_m_tvalid || i_m_tready;
    assign cmp_hit  = r_cval && (r_rdata == r_page);
    assign cmp_last = r_cval && ((NW'(r_cidx) + NW'(1)) == r_filled);

    assign rd_addr = (r_state == S_SCAN) ? r_idx[IW-1:0] : r_hand;
    assign wr_en   = (r_state == S_EVICT) || ((r_state == S_MISS) && (r_filled < n_act));

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_hand] <= r_page;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fiu      <= cscr_pkg::CFG_RESET;
            r_ref      <= '0;
            r_filled   <= '0;
            r_hand     <= '0;
            r_fault    <= '0;
            r_idx      <= '0;
            r_cval     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_fiu    <= i_cfg_data;
                        r_ref    <= '0;
                        r_filled <= '0;
                        r_hand   <= '0;
                    end else if (i_s_tvalid) begin
                        r_page  <= page_ext[PAGE_BITS-1:0];
                        r_idx   <= '0;
                        r_cval  <= 1'b0;
                        r_state <= (r_filled == '0) ? S_MISS : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one read issued, the previous one compared
                    r_cval <= (r_idx < r_filled);
                    r_cidx <= r_idx[IW-1:0];
                    r_idx  <= r_idx + NW'(1);
                    if (cmp_hit) begin
                        r_ref[r_cidx] <= 1'b1;
                        r_res_hit     <= 1'b1;
                        r_res_ev      <= 1'b0;
                        r_res_slot    <= r_cidx;
                        r_res_evp     <= '0;
                        r_state       <= S_OUT;
                    end else if (cmp_last) begin
                        r_state <= S_MISS;
                    end
                end
                S_MISS: begin
                    r_fault   <= r_fault + 32'd1;
                    r_res_hit <= 1'b0;
                    if (r_filled < n_act) begin
                        r_ref[r_hand] <= 1'b0;
                        r_filled      <= r_filled + NW'(1);
                        r_res_ev      <= 1'b0;
                        r_res_slot    <= r_hand;
                        r_res_evp     <= '0;
                        r_hand        <= hand_inc;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    // second chance: clear and pass over referenced frames
                    if (r_ref[r_hand]) begin
                        r_ref[r_hand] <= 1'b0;
                        r_hand        <= hand_inc;
                    end else begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    r_ref[r_hand] <= 1'b0;
                    r_res_ev      <= 1'b1;
                    r_res_slot    <= r_hand;
                    r_res_evp     <= r_rdata;
                    r_hand        <= hand_inc;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {4'd0, r_fault, evp_ext[15:0], slot_ext[3:0]};
                        r_m_tuser  <= {r_res_ev, r_res_hit};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= n_act)
        else $error("fill count above active frames");

    a_hand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_hand) < n_act)
        else $error("clock hand out of range");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[cscr_pkg::TU_HIT] && o_m_tuser[cscr_pkg::TU_EVICTED]))
        else $error("hit reported with eviction");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_filled == n_act))
        else $error("sweep with free frames");
`endif

endmodule
